// ----- rtl/core/acls_pkg.sv -----
// ----------------------------------------------------------------------------
// acls_pkg
// Shared types, codes and constants of the ADC clip level search block.
// ----------------------------------------------------------------------------
package acls_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned CountW  = 16;
	localparam int unsigned LevelW  = 7;
	localparam int unsigned StartW  = 5;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 16;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic [CfgIdxW-1:0] REG_WIDE_SAMPLES      = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_STOP_COUNT_NARROW = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_STOP_COUNT_WIDE   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_RAIL_HIT_WEIGHT   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CLIP_DECISION     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_START_LEVEL       = 3'd5;

	localparam logic [SampleW-1:0] NARROW_NEAR_LO = 16'h0008;
	localparam logic [SampleW-1:0] NARROW_NEAR_HI = 16'h00f8;
	localparam logic [SampleW-1:0] WIDE_NEAR_LO   = 16'h0800;
	localparam logic [SampleW-1:0] WIDE_NEAR_HI   = 16'hf800;
	localparam logic [SampleW-1:0] NARROW_RAIL    = 16'h00ff;
	localparam logic [SampleW-1:0] WIDE_RAIL      = 16'hffff;

	localparam logic signed [LevelW-1:0] LEVEL_MAX = 7'sd31;

	localparam logic [CountW-1:0] RST_STOP_NARROW = 16'd20;
	localparam logic [CountW-1:0] RST_STOP_WIDE   = 16'd10;
	localparam logic [CountW-1:0] RST_RAIL_WEIGHT = 16'd41;
	localparam logic [CountW-1:0] RST_DECISION    = 16'd20;
	localparam logic [StartW-1:0] RST_START_LEVEL = 5'd20;

	typedef enum logic [2:0] {
		PH_ASCEND  = 3'b001,
		PH_DESCEND = 3'b010,
		PH_DONE    = 3'b100
	} acls_phase_t;

	typedef struct packed {
		logic               restart;
		logic               last;
		logic [SampleW-1:0] sample;
	} acls_item_t;

	typedef struct packed {
		logic              wide;
		logic [CountW-1:0] stop_narrow;
		logic [CountW-1:0] stop_wide;
		logic [CountW-1:0] rail_weight;
	} acls_scan_cfg_t;

	typedef struct packed {
		logic [SampleW-1:0] low;
		logic [SampleW-1:0] high;
		logic [CountW-1:0]  count;
	} acls_stats_t;

endpackage

// ----- rtl/core/acls_if.sv -----
// ----------------------------------------------------------------------------
// acls_if
// Handshake channels of the ADC clip level search block.
// ----------------------------------------------------------------------------
interface acls_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] sample;
	logic        last;

	modport source (output valid, output opcode, output sample, output last, input ready);
	modport sink (input valid, input opcode, input sample, input last, output ready);
endinterface

interface acls_out_if;
	logic              valid;
	logic              ready;
	logic [15:0]       block_low;
	logic [15:0]       block_high;
	logic [15:0]       clip_count;
	logic signed [6:0] tested_level;
	logic signed [6:0] next_level;
	logic              search_done;

	modport source (
		output valid, output block_low, output block_high, output clip_count,
		output tested_level, output next_level, output search_done, input ready
	);
	modport sink (
		input valid, input block_low, input block_high, input clip_count,
		input tested_level, input next_level, input search_done, output ready
	);
endinterface

interface acls_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/acls_block_stats.sv -----
// ----------------------------------------------------------------------------
// acls_block_stats
// Per-block minimum, maximum and weighted near-rail count with early stop.
// ----------------------------------------------------------------------------
module acls_block_stats
	import acls_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  acls_item_t     item,
	input  acls_scan_cfg_t cfg,
	output acls_stats_t    stats
);

	logic [SampleW-1:0] low_q;
	logic [SampleW-1:0] high_q;
	logic [CountW-1:0]  count_q;

	logic [SampleW-1:0] samp;
	logic [SampleW-1:0] rail;
	logic [SampleW-1:0] near_lo;
	logic [SampleW-1:0] near_hi;
	logic [CountW-1:0]  stop;
	logic               scan;
	logic               near;
	logic               rail_hit;
	logic [CountW:0]    sum1;
	logic [CountW:0]    sum2;
	logic [CountW-1:0]  cnt1;
	logic [CountW-1:0]  cnt2;

	always_comb begin
		samp     = cfg.wide ? item.sample : {8'h00, item.sample[7:0]};
		rail     = cfg.wide ? WIDE_RAIL : NARROW_RAIL;
		near_lo  = cfg.wide ? WIDE_NEAR_LO : NARROW_NEAR_LO;
		near_hi  = cfg.wide ? WIDE_NEAR_HI : NARROW_NEAR_HI;
		stop     = cfg.wide ? cfg.stop_wide : cfg.stop_narrow;
		scan     = count_q < stop;
		near     = (samp < near_lo) || (samp > near_hi);
		rail_hit = (samp == '0) || (samp == rail);
		sum1     = {1'b0, count_q} + {{CountW{1'b0}}, near};
		cnt1     = sum1[CountW] ? {CountW{1'b1}} : sum1[CountW-1:0];
		sum2     = {1'b0, cnt1} + {1'b0, cfg.rail_weight};
		cnt2     = sum2[CountW] ? {CountW{1'b1}} : sum2[CountW-1:0];

		stats.low   = low_q;
		stats.high  = high_q;
		stats.count = count_q;
		if (scan) begin
			if (samp < low_q) begin
				stats.low = samp;
			end
			if (samp > high_q) begin
				stats.high = samp;
			end
			stats.count = rail_hit ? cnt2 : cnt1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= {SampleW{1'b1}};
			high_q  <= '0;
			count_q <= '0;
		end else if (step) begin
			if (item.restart || item.last) begin
				low_q   <= {SampleW{1'b1}};
				high_q  <= '0;
				count_q <= '0;
			end else begin
				low_q   <= stats.low;
				high_q  <= stats.high;
				count_q <= stats.count;
			end
		end
	end

endmodule

// ----- rtl/core/adc_clip_level_search.sv -----
// ----------------------------------------------------------------------------
// adc_clip_level_search
// ADC clip level search: block statistics and gain level stepping.
// ----------------------------------------------------------------------------
// One item is accepted per clock when the result side keeps up; an item sits
// in the input register, where the block statistics and the level
// step are worked out and the block-end result is written to the output
// register, so a result is valid once its last item leaves the input register.
// Throughput is set by the single input stage and the one-deep output
// register: a block end waits only while the previous result is not taken.
// Restart items and items in mid-block produce no result.
// ----------------------------------------------------------------------------
module adc_clip_level_search
	import acls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	acls_in_if.sink    samples,
	acls_out_if.source results,
	acls_cfg_if.sink   cfg
);

	logic               wide_q;
	logic [CountW-1:0]  stop_narrow_q;
	logic [CountW-1:0]  stop_wide_q;
	logic [CountW-1:0]  rail_weight_q;
	logic [CountW-1:0]  decision_q;
	logic [StartW-1:0]  start_level_q;

	logic               valid_s1;
	logic               opcode_s1;
	logic               last_s1;
	logic [SampleW-1:0] sample_s1;

	logic                     level_valid_q;
	logic [SampleW-1:0]       out_low_q;
	logic [SampleW-1:0]       out_high_q;
	logic [CountW-1:0]        out_count_q;
	logic signed [LevelW-1:0] out_tested_q;
	logic signed [LevelW-1:0] out_next_q;
	logic                     out_done_q;

	logic signed [LevelW-1:0] level_q;
	acls_phase_t              phase_q;

	acls_item_t               item;
	acls_scan_cfg_t           scan_cfg;
	acls_stats_t              stats;
	logic                     restart;
	logic                     produce;
	logic                     adv;
	acls_phase_t              phase_mid;
	acls_phase_t              phase_nxt;
	logic signed [LevelW-1:0] level_nxt;
	logic [SampleW-1:0]       rail;
	logic [SampleW-1:0]       low_rep;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q        <= 1'b0;
			stop_narrow_q <= RST_STOP_NARROW;
			stop_wide_q   <= RST_STOP_WIDE;
			rail_weight_q <= RST_RAIL_WEIGHT;
			decision_q    <= RST_DECISION;
			start_level_q <= RST_START_LEVEL;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WIDE_SAMPLES:      wide_q        <= cfg.data[0];
				REG_STOP_COUNT_NARROW: stop_narrow_q <= cfg.data;
				REG_STOP_COUNT_WIDE:   stop_wide_q   <= cfg.data;
				REG_RAIL_HIT_WEIGHT:   rail_weight_q <= cfg.data;
				REG_CLIP_DECISION:     decision_q    <= cfg.data;
				REG_START_LEVEL:       start_level_q <= cfg.data[StartW-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage
	assign restart = opcode_s1 == OP_RESTART;
	assign produce = !restart && last_s1;
	assign adv     = valid_s1 && (!produce || !level_valid_q || results.ready);
	assign samples.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			opcode_s1 <= samples.opcode;
			sample_s1 <= samples.sample;
			last_s1   <= samples.last;
		end
	end

	// block statistics
	assign item.restart = restart;
	assign item.last    = last_s1;
	assign item.sample  = sample_s1;

	assign scan_cfg.wide        = wide_q;
	assign scan_cfg.stop_narrow = stop_narrow_q;
	assign scan_cfg.stop_wide   = stop_wide_q;
	assign scan_cfg.rail_weight = rail_weight_q;

	acls_block_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item),
		.cfg    (scan_cfg),
		.stats  (stats)
	);

	// level search step
	always_comb begin
		phase_mid = phase_q;
		if (phase_q != PH_DONE) begin
			if (stats.count >= decision_q) begin
				phase_mid = PH_DESCEND;
			end else if (phase_q == PH_DESCEND) begin
				phase_mid = PH_DONE;
			end
		end

		unique case (phase_mid)
			PH_ASCEND:  level_nxt = level_q + 7'sd1;
			PH_DESCEND: level_nxt = level_q - 7'sd1;
			PH_DONE:    level_nxt = level_q;
			default:    level_nxt = level_q;
		endcase

		phase_nxt = phase_mid;
		if (level_nxt < 7'sd0 || level_nxt > LEVEL_MAX) begin
			phase_nxt = PH_DONE;
		end

		rail    = wide_q ? WIDE_RAIL : NARROW_RAIL;
		low_rep = (stats.low > rail) ? rail : stats.low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LevelW'(RST_START_LEVEL);
			phase_q <= PH_ASCEND;
		end else if (adv) begin
			if (restart) begin
				level_q <= LevelW'(start_level_q);
				phase_q <= PH_ASCEND;
			end else if (last_s1) begin
				level_q <= level_nxt;
				phase_q <= phase_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_valid_q <= 1'b0;
		end else if (adv && produce) begin
			level_valid_q <= 1'b1;
		end else if (results.ready) begin
			level_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			out_low_q    <= low_rep;
			out_high_q   <= stats.high;
			out_count_q  <= stats.count;
			out_tested_q <= level_q;
			out_next_q   <= level_nxt;
			out_done_q   <= phase_nxt == PH_DONE;
		end
	end

	assign results.valid        = level_valid_q;
	assign results.block_low    = out_low_q;
	assign results.block_high   = out_high_q;
	assign results.clip_count   = out_count_q;
	assign results.tested_level = out_tested_q;
	assign results.next_level   = out_next_q;
	assign results.search_done  = out_done_q;

	// checks
	a_restart_loads_level: assert property (@(posedge clk) disable iff (!arst_n)
		adv && restart |=> level_q == LevelW'($past(start_level_q)) && phase_q == PH_ASCEND)
		else $error("restart did not load the start level");

	a_block_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && produce |=> results.valid)
		else $error("block end without a result");

	a_done_holds_level: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !restart && phase_q == PH_DONE |=> level_q == $past(level_q))
		else $error("level moved after the search finished");

	a_range_means_done: assert property (@(posedge clk) disable iff (!arst_n)
		level_q < 7'sd0 || level_q > LEVEL_MAX |-> phase_q == PH_DONE)
		else $error("level out of range while searching");

endmodule

// ----- verif/tb_adc_clip_level_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_clip_level_search
// Self-checking bench for the ADC clip level search block. A predictor
// follows every accepted item and register write and queues the block-end
// report it expects. Each report is checked against the oldest queued one.
// Directed tests cover the rails, the near-rail bounds, mode changes,
// saturation and the level limits. Random phases then vary all registers
// while both channels stall at random.
// ----------------------------------------------------------------------------
module tb_adc_clip_level_search;
	import acls_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [15:0]       low;
		logic [15:0]       high;
		logic [15:0]       count;
		logic signed [6:0] tested;
		logic signed [6:0] nxt_level;
		logic              done;
	} block_report_t;

	logic clk;
	logic arst_n;

	acls_in_if  in_ch ();
	acls_out_if res_ch ();
	acls_cfg_if cfg_ch ();

	adc_clip_level_search i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (in_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	// predictor state
	logic        cfg_wide;
	logic [15:0] cfg_stop_narrow;
	logic [15:0] cfg_stop_wide;
	logic [15:0] cfg_weight;
	logic [15:0] cfg_decision;
	logic [4:0]  cfg_start;
	logic [15:0] acc_low;
	logic [15:0] acc_high;
	logic [15:0] acc_count;
	int          gain_lvl;
	acls_phase_t search_ph;

	block_report_t pending_reports[$];

	logic stall_enable;
	int   idle_cycles;
	int   ready_hold;
	int   mismatches;
	int   n_items;
	int   n_restarts;
	int   n_reports;
	int   n_reg_writes;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hffff : s[15:0];
	endfunction

	function automatic void clear_block();
		acc_low   = 16'hffff;
		acc_high  = 16'h0000;
		acc_count = 16'h0000;
	endfunction

	function automatic void step_search(logic op, logic [15:0] smp, logic lst);
		logic [15:0]   rail;
		logic [15:0]   stop;
		logic [15:0]   nlo;
		logic [15:0]   nhi;
		logic [15:0]   s;
		int            tested;
		block_report_t rep;
		rail = cfg_wide ? WIDE_RAIL : NARROW_RAIL;
		stop = cfg_wide ? cfg_stop_wide : cfg_stop_narrow;
		nlo  = cfg_wide ? WIDE_NEAR_LO : NARROW_NEAR_LO;
		nhi  = cfg_wide ? WIDE_NEAR_HI : NARROW_NEAR_HI;
		if (op == OP_RESTART) begin
			gain_lvl  = int'(cfg_start);
			search_ph = PH_ASCEND;
			clear_block();
			return;
		end
		s = cfg_wide ? smp : {8'h00, smp[7:0]};
		if (acc_count < stop) begin
			if (s < acc_low)
				acc_low = s;
			if (s > acc_high)
				acc_high = s;
			if (s < nlo || s > nhi)
				acc_count = sat_add16(acc_count, 16'd1);
			if (s == 16'h0000 || s == rail)
				acc_count = sat_add16(acc_count, cfg_weight);
		end
		if (!lst)
			return;
		tested = gain_lvl;
		if (search_ph != PH_DONE) begin
			if (acc_count >= cfg_decision)
				search_ph = PH_DESCEND;
			else if (search_ph == PH_DESCEND)
				search_ph = PH_DONE;
			if (search_ph == PH_ASCEND)
				gain_lvl++;
			else if (search_ph == PH_DESCEND)
				gain_lvl--;
			if (gain_lvl < 0 || gain_lvl > int'(LEVEL_MAX))
				search_ph = PH_DONE;
		end
		rep.low       = (acc_low > rail) ? rail : acc_low;
		rep.high      = acc_high;
		rep.count     = acc_count;
		rep.tested    = 7'(tested);
		rep.nxt_level = 7'(gain_lvl);
		rep.done      = (search_ph == PH_DONE);
		pending_reports.push_back(rep);
		clear_block();
	endfunction

	function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [15:0] d);
		case (idx)
			REG_WIDE_SAMPLES:      cfg_wide        = d[0];
			REG_STOP_COUNT_NARROW: cfg_stop_narrow = d;
			REG_STOP_COUNT_WIDE:   cfg_stop_wide   = d;
			REG_RAIL_HIT_WEIGHT:   cfg_weight      = d;
			REG_CLIP_DECISION:     cfg_decision    = d;
			REG_START_LEVEL:       cfg_start       = d[4:0];
			default: ;
		endcase
	endfunction

	// result side: check and random stalls
	always @(posedge clk) begin : result_check
		block_report_t got;
		block_report_t want;
		if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.block_low, res_ch.block_high, res_ch.clip_count,
				res_ch.tested_level, res_ch.next_level, res_ch.search_done};
			n_reports++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected report low=%h high=%h count=%h", $realtime,
						got.low, got.high, got.count);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: report mismatch", $realtime);
						$display("  exp low=%h high=%h count=%h tested=%0d next=%0d done=%b",
							want.low, want.high, want.count, want.tested, want.nxt_level,
							want.done);
						$display("  got low=%h high=%h count=%h tested=%0d next=%0d done=%b",
							got.low, got.high, got.count, got.tested, got.nxt_level,
							got.done);
					end
				end
			end
		end
		if (ready_hold > 0) begin
			res_ch.ready <= 1'b0;
			ready_hold--;
		end else if (stall_enable && $urandom_range(0, 5) == 0) begin
			res_ch.ready <= 1'b0;
			ready_hold = $urandom_range(1, 14) - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_item(logic op, logic [15:0] smp, logic lst);
		if (stall_enable && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.opcode <= op;
		in_ch.sample <= smp;
		in_ch.last   <= lst;
		do @(posedge clk); while (!in_ch.ready);
		step_search(op, smp, lst);
		n_items++;
		if (op == OP_RESTART)
			n_restarts++;
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(logic wide, logic [15:0] stop_n, logic [15:0] stop_w,
			logic [15:0] weight, logic [15:0] decision, logic [4:0] start);
		logic [CfgIdxW-1:0] idx [6];
		logic [15:0]        val [6];
		settle();
		idx[0] = REG_WIDE_SAMPLES;      val[0] = {15'd0, wide};
		idx[1] = REG_STOP_COUNT_NARROW; val[1] = stop_n;
		idx[2] = REG_STOP_COUNT_WIDE;   val[2] = stop_w;
		idx[3] = REG_RAIL_HIT_WEIGHT;   val[3] = weight;
		idx[4] = REG_CLIP_DECISION;     val[4] = decision;
		idx[5] = REG_START_LEVEL;       val[5] = {11'd0, start};
		for (int i = 0; i < 6; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
			apply_reg(idx[i], val[i]);
			n_reg_writes++;
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_restart();
		send_item(OP_RESTART, 16'($urandom_range(0, 16'hffff)), 1'($urandom_range(0, 1)));
	endtask

	function automatic logic [15:0] pick_sample();
		logic [7:0] hb;
		hb = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 7))
			0:       return cfg_wide ? 16'h0000 : {hb, 8'h00};
			1:       return cfg_wide ? 16'hffff : {hb, 8'hff};
			2:       return cfg_wide ? 16'($urandom_range(0, 16'h0fff)) :
				{hb, 8'($urandom_range(0, 8'h0f))};
			3:       return cfg_wide ? 16'($urandom_range(16'hf000, 16'hffff)) :
				{hb, 8'($urandom_range(8'hf0, 8'hff))};
			default: return 16'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	function automatic logic [15:0] pick_reg16();
		case ($urandom_range(0, 6))
			0:       return 16'h0000;
			1:       return 16'hffff;
			2:       return 16'h0001;
			3:       return 16'($urandom_range(0, 16'hffff));
			default: return 16'($urandom_range(2, 60));
		endcase
	endfunction

	task automatic random_items(int count);
		int left;
		int len;
		left = count;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
			for (int k = 0; k < len && left > 0; k++) begin
				if ($urandom_range(0, 24) == 0)
					send_restart();
				else
					send_item(OP_SAMPLE, pick_sample(), k == len - 1);
				left--;
			end
		end
	endtask

	task automatic test_narrow_bounds();
		load_regs(1'b0, 16'hffff, 16'd10, 16'd3, 16'd20, 5'd20);
		send_item(OP_SAMPLE, 16'h1200, 1'b0);
		send_item(OP_SAMPLE, 16'h00ff, 1'b0);
		send_item(OP_SAMPLE, 16'h0007, 1'b0);
		send_item(OP_SAMPLE, 16'h0008, 1'b0);
		send_item(OP_SAMPLE, 16'h00f8, 1'b0);
		send_item(OP_SAMPLE, 16'h00f9, 1'b0);
		send_item(OP_SAMPLE, 16'hab80, 1'b1);
		send_item(OP_RESTART, 16'h5a5a, 1'b1);
	endtask

	task automatic test_wide_bounds();
		load_regs(1'b1, 16'd20, 16'hffff, 16'd2, 16'd65535, 5'd20);
		send_item(OP_SAMPLE, 16'h0000, 1'b0);
		send_item(OP_SAMPLE, 16'hffff, 1'b0);
		send_item(OP_SAMPLE, 16'h07ff, 1'b0);
		send_item(OP_SAMPLE, 16'h0800, 1'b0);
		send_item(OP_SAMPLE, 16'hf800, 1'b0);
		send_item(OP_SAMPLE, 16'hf801, 1'b1);
	endtask

	task automatic test_mode_switch();
		send_item(OP_SAMPLE, 16'h1234, 1'b0);
		load_regs(1'b0, 16'd20, 16'd10, 16'd41, 16'd20, 5'd20);
		send_item(OP_SAMPLE, 16'h0050, 1'b1);
	endtask

	task automatic test_stop_zero_and_saturation();
		load_regs(1'b0, 16'h0000, 16'd10, 16'd41, 16'd20, 5'd20);
		send_item(OP_SAMPLE, 16'h0000, 1'b1);
		load_regs(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'd20, 5'd20);
		send_item(OP_SAMPLE, 16'h0000, 1'b0);
		send_item(OP_SAMPLE, 16'h00ff, 1'b1);
	endtask

	task automatic test_level_limits();
		load_regs(1'b0, 16'd20, 16'd10, 16'd41, 16'hffff, 5'd31);
		send_restart();
		send_item(OP_SAMPLE, 16'h0080, 1'b1);
		send_item(OP_SAMPLE, 16'h0000, 1'b1);
		load_regs(1'b1, 16'd20, 16'd10, 16'd41, 16'h0000, 5'd0);
		send_restart();
		send_item(OP_SAMPLE, 16'h8000, 1'b1);
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 12; ph++) begin
			load_regs(1'($urandom_range(0, 1)), pick_reg16(), pick_reg16(), pick_reg16(),
				pick_reg16(), ($urandom_range(0, 3) == 0) ? 5'(31 * $urandom_range(0, 1)) :
				5'($urandom_range(0, 31)));
			if ($urandom_range(0, 1) == 0)
				send_restart();
			random_items(100);
		end
	endtask

	task automatic test_back_to_back();
		settle();
		stall_enable = 1'b0;
		send_restart();
		random_items(150);
	endtask

	initial begin
		arst_n       = 1'b0;
		stall_enable = 1'b1;
		idle_cycles  = 0;
		ready_hold   = 0;
		mismatches   = 0;
		n_items      = 0;
		n_restarts   = 0;
		n_reports    = 0;
		n_reg_writes = 0;
		cfg_wide        = 1'b0;
		cfg_stop_narrow = RST_STOP_NARROW;
		cfg_stop_wide   = RST_STOP_WIDE;
		cfg_weight      = RST_RAIL_WEIGHT;
		cfg_decision    = RST_DECISION;
		cfg_start       = RST_START_LEVEL;
		gain_lvl        = int'(RST_START_LEVEL);
		search_ph       = PH_ASCEND;
		clear_block();
		in_ch.valid   <= 1'b0;
		in_ch.opcode  <= OP_SAMPLE;
		in_ch.sample  <= 16'h0000;
		in_ch.last    <= 1'b0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= REG_WIDE_SAMPLES;
		cfg_ch.data   <= 16'h0000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_SAMPLE, 16'h0000, 1'b1);
		test_narrow_bounds();
		test_wide_bounds();
		test_mode_switch();
		test_stop_zero_and_saturation();
		test_level_limits();
		test_random_phases();
		test_back_to_back();

		in_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d items (%0d restarts), %0d block reports, %0d register writes",
			n_items, n_restarts, n_reports, n_reg_writes);
		$display("narrow and wide modes, rail hits, early stop, saturation, level limits");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/acls_pkg.sv
rtl/core/acls_if.sv
rtl/core/acls_block_stats.sv
rtl/core/adc_clip_level_search.sv
verif/tb_adc_clip_level_search.sv
